@@ hw/rtl/wear_leveled_index_log_macros.svh @@
// Assertion macros for the wear-levelled index log.
// The using module provides clk and rst_n; checks are off while in reset.
`ifndef WEAR_LEVELED_INDEX_LOG_MACROS_SVH
`define WEAR_LEVELED_INDEX_LOG_MACROS_SVH

// Condition holds at every clock edge
`define WLIL_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define WLIL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/wllog_pkg.sv @@
// Shared types and constants for the wear-levelled index log.
// No dependencies; used by the top level, the slot memory and the controller.
`timescale 1ns / 1ps

package wllog_pkg;

  localparam int SLOT_COUNT  = 256;
  localparam int ENTRY_COUNT = 80;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W       = SLOT_W + 1;

  localparam logic [31:0] LOG_MARKER = 32'h5A5A_5A5A;
  localparam logic [31:0] LOW_ERASED = 32'hFFFF_FFFF;
  localparam logic [15:0] FILL_BITS  = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_SAVE    = 2'd0,
    MODE_LOAD    = 2'd1,
    MODE_RESTORE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [63:0]       wr_data;
    logic              erase;
  } mem_req_t;

endpackage

@@ hw/rtl/wllog_if.sv @@
// Valid/ready channel interfaces for the wear-levelled index log.
// Self-contained; the payload widths follow the item formats.
`timescale 1ns / 1ps

interface wllog_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  entry_index;
  logic [7:0]  slot_number;
  logic [63:0] raw_word;

  modport source (output valid, mode, entry_index, slot_number, raw_word, input ready);
  modport sink   (input valid, mode, entry_index, slot_number, raw_word, output ready);
endinterface

interface wllog_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] current_value;
  logic [7:0] slot_touched;
  logic       page_was_erased;
  logic       found_valid;

  modport source (output valid, status, current_value, slot_touched, page_was_erased,
                  found_valid, input ready);
  modport sink   (input valid, status, current_value, slot_touched, page_was_erased,
                  found_valid, output ready);
endinterface

@@ hw/rtl/wear_leveled_index_log.sv @@
// Wear-levelled index log. A save scans the page one slot per cycle through the
// single read port of the slot memory and stops at the first free slot; when the
// page is full, it gets erased. A restore always scans the whole page. A raw
// load, a rejected save and an unused mode skip the scan. The page erase clears
// all per-slot valid bits at once, and reset needs no clearing pass. One item is
// in work at a time; the result register lets the next item be taken while a
// result waits to be collected.
`timescale 1ns / 1ps

module wear_leveled_index_log (
  input logic          clk,
  input logic          rst_n,
  wllog_in_if.sink     in_ch,
  wllog_out_if.source  out_ch
);

  wllog_pkg::mem_req_t mem_req;
  logic [63:0]         mem_rd_data;

  wllog_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  wllog_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

@@ hw/rtl/wllog_mem.sv @@
// Slot memory: one read port with registered data, one write port, page erase.
// Depends on wllog_pkg. Per-slot valid bits make erased slots read as all ones.
`timescale 1ns / 1ps

module wllog_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  wllog_pkg::mem_req_t req,
  output logic [63:0]         rd_data
);

  logic [63:0]                     mem_r [wllog_pkg::SLOT_COUNT];
  logic [wllog_pkg::SLOT_COUNT-1:0] vld_r, vld_nxt;
  logic [63:0]                     rd_data_r;
  logic                            rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem_r[req.rd_addr];
    end
  end

  // Erase drops every valid bit; a write in the same cycle re-marks its slot
  always_comb begin
    vld_nxt = req.erase ? '0 : vld_r;
    if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '1;

endmodule

@@ hw/rtl/wllog_ctrl.sv @@
// Controller: takes an item, scans the slot memory one slot per cycle for a save
// or a restore, writes back and holds the result transaction. Depends on
// wllog_pkg, the channel interfaces and the assertion macros.
`timescale 1ns / 1ps

`include "wear_leveled_index_log_macros.svh"

module wllog_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  wllog_in_if.sink             in_ch,
  wllog_out_if.source          out_ch,
  output wllog_pkg::mem_req_t  req,
  input  logic [63:0]          rd_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                         state_r, state_nxt;
  logic [wllog_pkg::CNT_W-1:0]    iss_cnt_r, iss_cnt_nxt;
  logic                           pend_r;
  logic [wllog_pkg::SLOT_W-1:0]   pend_addr_r;
  logic [wllog_pkg::SLOT_W-1:0]   pos_r, pos_nxt;
  logic                           erase_r, erase_nxt;
  logic                           have_r, have_nxt;
  logic [7:0]                     val_r, val_nxt;
  logic [7:0]                     cur_r, cur_nxt;

  wllog_pkg::mode_t               mode_r;
  logic [7:0]                     idx_r;
  logic [7:0]                     slot_r;
  logic [63:0]                    raw_r;

  logic                           out_valid_r, out_valid_nxt;
  logic                           status_r, status_nxt;
  logic [7:0]                     touched_r, touched_nxt;
  logic                           erased_r, erased_nxt;
  logic                           found_r, found_nxt;

  wllog_pkg::mode_t               in_mode;
  logic                           in_fire;
  logic                           out_free;
  logic                           save_ok;
  logic                           is_last;
  logic                           word_valid;
  logic [63:0]                    save_word;

  assign in_mode  = wllog_pkg::mode_t'(in_ch.mode);
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign save_ok  = idx_r < 8'(wllog_pkg::ENTRY_COUNT);
  assign is_last  = pend_addr_r == wllog_pkg::SLOT_W'(wllog_pkg::SLOT_COUNT - 1);
  assign word_valid = (rd_data[31:0] != wllog_pkg::LOW_ERASED) &&
                      (rd_data[63:32] == wllog_pkg::LOG_MARKER) &&
                      (rd_data[15:8] == ~rd_data[7:0]);
  assign save_word = {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, ~idx_r, idx_r};

  always_comb begin
    state_nxt     = state_r;
    iss_cnt_nxt   = iss_cnt_r;
    pos_nxt       = pos_r;
    erase_nxt     = erase_r;
    have_nxt      = have_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    touched_nxt   = touched_r;
    erased_nxt    = erased_r;
    found_nxt     = found_r;
    req           = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          iss_cnt_nxt = '0;
          have_nxt    = 1'b0;
          if ((in_mode == wllog_pkg::MODE_SAVE &&
               in_ch.entry_index < 8'(wllog_pkg::ENTRY_COUNT)) ||
              in_mode == wllog_pkg::MODE_RESTORE) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous slot's data comes back
        if (iss_cnt_r < wllog_pkg::CNT_W'(wllog_pkg::SLOT_COUNT)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = iss_cnt_r[wllog_pkg::SLOT_W-1:0];
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (pend_r) begin
          if (mode_r == wllog_pkg::MODE_SAVE) begin
            if (rd_data[31:0] == wllog_pkg::LOW_ERASED) begin
              pos_nxt   = pend_addr_r;
              erase_nxt = 1'b0;
              state_nxt = ST_DONE;
            end else if (is_last) begin
              pos_nxt   = '0;
              erase_nxt = 1'b1;
              state_nxt = ST_DONE;
            end
          end else begin
            if (word_valid) begin
              pos_nxt  = pend_addr_r;
              have_nxt = 1'b1;
              val_nxt  = rd_data[7:0];
            end
            if (is_last) begin
              state_nxt = ST_DONE;
            end
          end
        end
      end

      ST_DONE: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = 1'b0;
          touched_nxt   = '0;
          erased_nxt    = 1'b0;
          found_nxt     = 1'b0;
          case (mode_r)
            wllog_pkg::MODE_SAVE: begin
              if (save_ok) begin
                req.wr_en   = 1'b1;
                req.wr_addr = pos_r;
                req.wr_data = save_word;
                req.erase   = erase_r;
                cur_nxt     = idx_r;
                touched_nxt = 8'(pos_r);
                erased_nxt  = erase_r;
              end else begin
                status_nxt = 1'b1;
              end
            end
            wllog_pkg::MODE_LOAD: begin
              if ({24'd0, slot_r} < 32'(wllog_pkg::SLOT_COUNT)) begin
                req.wr_en   = 1'b1;
                req.wr_addr = wllog_pkg::SLOT_W'(slot_r);
                req.wr_data = raw_r;
              end
              touched_nxt = slot_r;
            end
            wllog_pkg::MODE_RESTORE: begin
              if (have_r) begin
                cur_nxt     = (val_r < 8'(wllog_pkg::ENTRY_COUNT)) ? val_r : 8'd0;
                touched_nxt = 8'(pos_r);
                found_nxt   = 1'b1;
              end else begin
                cur_nxt = 8'd0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= 1'b0;
      cur_r       <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= req.rd_en;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_cnt_r   <= iss_cnt_nxt;
    pend_addr_r <= req.rd_addr;
    pos_r       <= pos_nxt;
    erase_r     <= erase_nxt;
    have_r      <= have_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    touched_r   <= touched_nxt;
    erased_r    <= erased_nxt;
    found_r     <= found_nxt;
    if (in_fire) begin
      mode_r <= in_mode;
      idx_r  <= in_ch.entry_index;
      slot_r <= in_ch.slot_number;
      raw_r  <= in_ch.raw_word;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.current_value   = cur_r;
  assign out_ch.slot_touched    = touched_r;
  assign out_ch.page_was_erased = erased_r;
  assign out_ch.found_valid     = found_r;

  `WLIL_ASSERT(a_no_rd_wr_overlap, !(req.rd_en && req.wr_en), "slot read and write overlap")
  `WLIL_ASSERT(a_erase_with_slot0, !req.erase || (req.wr_en && req.wr_addr == '0), "erase without write to slot 0")
  `WLIL_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE, "accepted item left controller idle")
  `WLIL_ASSERT_NEXT(a_result_held, out_valid_r && !out_ch.ready, out_valid_r && $stable(touched_r), "pending result changed")

endmodule

@@ tb/wear_leveled_index_log_tb.sv @@
// Self-checking testbench for the wear-levelled index log: a directed table, then
// random traffic under several idle/stall mixes, checked against a local log model.
// Depends on wllog_pkg and the channel interfaces in wllog_if.sv.
`timescale 1ns / 1ps

module wear_leveled_index_log_tb;

  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES    = wllog_pkg::SLOT_COUNT + 16;
  localparam int HOLD_OFF_CYCLES = 600;

  typedef struct packed {
    wllog_pkg::mode_t mode;
    logic [7:0]       entry_index;
    logic [7:0]       slot_number;
    logic [63:0]      raw_word;
  } log_req_t;

  typedef struct packed {
    logic       status;
    logic [7:0] current_value;
    logic [7:0] slot_touched;
    logic       page_was_erased;
    logic       found_valid;
  } log_result_t;

  typedef struct packed {
    log_req_t    req;
    logic        typed;
    log_result_t result;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wllog_in_if  in_if ();
  wllog_out_if out_if ();

  wear_leveled_index_log u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the page and the current index
  logic [63:0] slot_image [wllog_pkg::SLOT_COUNT];
  logic [7:0]  saved_index;

  log_result_t pending_results [$];
  int          error_count    = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_request   = 0;

  // Typed expectations only where the answer is obvious; the rest go to the model
  directed_row_t directed_rows [25] = '{
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_SAVE, 8'd80, 8'd0, 64'd0}, 1'b1,
      '{1'b1, 8'd0, 8'd0, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_SAVE, 8'd255, 8'd255, '1}, 1'b1,
      '{1'b1, 8'd0, 8'd0, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_SAVE, 8'd0, 8'd0, 64'd0}, 1'b1,
      '{1'b0, 8'd0, 8'd0, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_SAVE, 8'd79, 8'd0, 64'd0}, 1'b1,
      '{1'b0, 8'd79, 8'd1, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_NONE, 8'd255, 8'd255, '1}, 1'b1,
      '{1'b0, 8'd79, 8'd0, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b1,
      '{1'b0, 8'd79, 8'd1, 1'b0, 1'b1}},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd255, 64'd0}, 1'b1,
      '{1'b0, 8'd79, 8'd255, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd200,
        {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, 8'h37, 8'hC8}},
      1'b1, '{1'b0, 8'd79, 8'd200, 1'b0, 1'b0}},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd255,
        {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, 8'hFA, 8'h05}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd255,
        {wllog_pkg::LOG_MARKER, wllog_pkg::LOW_ERASED}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd200,
        {32'h5A5A_5A5B, wllog_pkg::FILL_BITS, 8'hF6, 8'h09}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd1,
        {wllog_pkg::LOG_MARKER, 16'h0000, 8'hFC, 8'h03}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd0,
        {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, 8'h00, 8'h07}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd0, '1}, 1'b0, '0},
    '{'{wllog_pkg::MODE_SAVE, 8'd42, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_LOAD, 8'd0, 8'd2,
        {32'h1234_5678, wllog_pkg::LOW_ERASED}}, 1'b0, '0},
    '{'{wllog_pkg::MODE_SAVE, 8'd17, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_RESTORE, 8'd0, 8'd0, 64'd0}, 1'b0, '0},
    '{'{wllog_pkg::MODE_SAVE, 8'd0, 8'd255, '1}, 1'b0, '0}
  };

  function automatic log_result_t log_model_step(input log_req_t r);
    log_result_t res;
    int          free_slot;
    int          last_valid;
    logic [63:0] w;
    res = '0;
    case (r.mode)
      wllog_pkg::MODE_SAVE: begin
        if (r.entry_index >= wllog_pkg::ENTRY_COUNT) begin
          res.status = 1'b1;
        end else begin
          saved_index = r.entry_index;
          free_slot = -1;
          for (int i = 0; i < wllog_pkg::SLOT_COUNT; i++) begin
            if (free_slot < 0 && slot_image[i][31:0] == wllog_pkg::LOW_ERASED)
              free_slot = i;
          end
          // Page full: erase everything and restart at the bottom
          if (free_slot < 0) begin
            foreach (slot_image[i]) slot_image[i] = '1;
            free_slot = 0;
            res.page_was_erased = 1'b1;
          end
          slot_image[free_slot] = {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS,
                                   ~r.entry_index, r.entry_index};
          res.slot_touched = free_slot[7:0];
        end
      end
      wllog_pkg::MODE_LOAD: begin
        if (r.slot_number < wllog_pkg::SLOT_COUNT) slot_image[r.slot_number] = r.raw_word;
        res.slot_touched = r.slot_number;
      end
      wllog_pkg::MODE_RESTORE: begin
        last_valid = -1;
        for (int i = 0; i < wllog_pkg::SLOT_COUNT; i++) begin
          w = slot_image[i];
          if (w[31:0] != wllog_pkg::LOW_ERASED && w[63:32] == wllog_pkg::LOG_MARKER &&
              w[15:8] == ~w[7:0])
            last_valid = i;
        end
        if (last_valid >= 0) begin
          w = slot_image[last_valid];
          saved_index = (w[7:0] >= wllog_pkg::ENTRY_COUNT) ? 8'd0 : w[7:0];
          res.slot_touched = last_valid[7:0];
          res.found_valid = 1'b1;
        end else begin
          saved_index = 8'd0;
        end
      end
      default: ;
    endcase
    res.current_value = saved_index;
    return res;
  endfunction

  function automatic log_req_t random_request();
    log_req_t   r;
    int         pick;
    int         kind;
    logic [7:0] v;
    r.entry_index = 8'($urandom);
    r.slot_number = 8'($urandom);
    r.raw_word    = {$urandom, $urandom};
    v             = 8'($urandom);
    pick          = $urandom_range(99);
    if (pick < 60) begin
      r.mode = wllog_pkg::MODE_SAVE;
      if ($urandom_range(9) != 0)
        r.entry_index = 8'($urandom_range(wllog_pkg::ENTRY_COUNT - 1));
    end else if (pick < 80) begin
      r.mode = wllog_pkg::MODE_LOAD;
      kind = $urandom_range(99);
      // Mix of erased slots, well-formed words, near misses and noise
      if (kind < 15) begin
        r.raw_word = '1;
      end else if (kind < 50) begin
        r.raw_word = {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, ~v, v};
      end else if (kind < 75) begin
        r.raw_word = {wllog_pkg::LOG_MARKER, wllog_pkg::FILL_BITS, ~v, v};
        r.raw_word[$urandom_range(63)] ^= 1'b1;
      end
    end else if (pick < 95) begin
      r.mode = wllog_pkg::MODE_RESTORE;
    end else begin
      r.mode = wllog_pkg::MODE_NONE;
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_log_result(input log_result_t got);
    log_result_t want;
    if (pending_results.size() == 0) begin
      log_mismatch("result transaction with nothing outstanding");
    end else begin
      want = pending_results.pop_front();
      if (got.status !== want.status)
        log_mismatch($sformatf("status %b, expected %b", got.status, want.status));
      if (got.current_value !== want.current_value)
        log_mismatch($sformatf("current_value %0d, expected %0d",
                               got.current_value, want.current_value));
      if (got.slot_touched !== want.slot_touched)
        log_mismatch($sformatf("slot_touched %0d, expected %0d",
                               got.slot_touched, want.slot_touched));
      if (got.page_was_erased !== want.page_was_erased)
        log_mismatch($sformatf("page_was_erased %b, expected %b",
                               got.page_was_erased, want.page_was_erased));
      if (got.found_valid !== want.found_valid)
        log_mismatch($sformatf("found_valid %b, expected %b",
                               got.found_valid, want.found_valid));
    end
  endtask

  // Offer one transaction; valid stays high into the next one unless a gap is drawn
  task automatic offer_request(input log_req_t r, input logic typed,
                               input log_result_t typed_result);
    log_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.mode        <= r.mode;
    in_if.entry_index <= r.entry_index;
    in_if.slot_number <= r.slot_number;
    in_if.raw_word    <= r.raw_word;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    predicted = log_model_step(r);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Result side: check at each edge, then draw ready for the next one
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        check_log_result({out_if.status, out_if.current_value, out_if.slot_touched,
                          out_if.page_was_erased, out_if.found_valid});
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (!rst_n) begin
        out_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int phase_send [4];
    int phase_recv [4];
    phase_send = '{0, 83, 0, 31};
    phase_recv = '{0, 0, 83, 31};
    in_if.valid       = 1'b0;
    in_if.mode        = wllog_pkg::MODE_SAVE;
    in_if.entry_index = '0;
    in_if.slot_number = '0;
    in_if.raw_word    = '0;
    foreach (slot_image[i]) slot_image[i] = '1;
    saved_index = 8'd0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].result);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      repeat (ITEMS_PER_PHASE) offer_request(random_request(), 1'b0, '0);
    end

    // Hold the result side off so the block backs up into the input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_OFF_CYCLES;
    repeat (ITEMS_PER_PHASE) offer_request(random_request(), 1'b0, '0);
    in_if.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
